@@ rtl/ptbo_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbo_pkg
// Shared types, constants and font for the pixel text and box overlay.
// ----------------------------------------------------------------------------
package ptbo_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int LABEL_CHARS   = 8;
    localparam int BAND_ROWS     = 7;
    localparam int GLYPH_COUNT   = 38;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [5:0] GLYPH_SPACE   = 6'd36;
    localparam logic [5:0] GLYPH_PERCENT = 6'd37;
    localparam logic [5:0] GLYPH_NONE    = 6'd38;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_BOX_LEFT   = 3'd1,
        REG_BOX_TOP    = 3'd2,
        REG_BOX_WIDTH  = 3'd3,
        REG_BOX_HEIGHT = 3'd4,
        REG_CONFIDENCE = 3'd5,
        REG_LABEL      = 3'd6
    } ptbo_reg_t;

    typedef struct packed {
        logic               overlay_enable;
        logic signed [8:0]  box_left;
        logic signed [8:0]  box_top;
        logic [7:0]         box_width;
        logic [7:0]         box_height;
        logic [7:0]         confidence_value;
        logic [63:0]        label_text;
    } ptbo_cfg_t;

    // Each glyph is five rows of three bits, top row in the high bits.
    localparam logic [14:0] FONT [GLYPH_COUNT] = '{
        {3'h7,3'h5,3'h5,3'h5,3'h7}, {3'h2,3'h6,3'h2,3'h2,3'h7}, {3'h7,3'h1,3'h7,3'h4,3'h7},
        {3'h7,3'h1,3'h7,3'h1,3'h7}, {3'h5,3'h5,3'h7,3'h1,3'h1}, {3'h7,3'h4,3'h7,3'h1,3'h7},
        {3'h7,3'h4,3'h7,3'h5,3'h7}, {3'h7,3'h1,3'h1,3'h1,3'h1}, {3'h7,3'h5,3'h7,3'h5,3'h7},
        {3'h7,3'h5,3'h7,3'h1,3'h7},
        {3'h2,3'h5,3'h7,3'h5,3'h5}, {3'h6,3'h5,3'h6,3'h5,3'h6}, {3'h7,3'h4,3'h4,3'h4,3'h7},
        {3'h6,3'h5,3'h5,3'h5,3'h6}, {3'h7,3'h4,3'h7,3'h4,3'h7}, {3'h7,3'h4,3'h7,3'h4,3'h4},
        {3'h7,3'h4,3'h5,3'h5,3'h7}, {3'h5,3'h5,3'h7,3'h5,3'h5}, {3'h7,3'h2,3'h2,3'h2,3'h7},
        {3'h1,3'h1,3'h1,3'h5,3'h7}, {3'h5,3'h5,3'h6,3'h5,3'h5}, {3'h4,3'h4,3'h4,3'h4,3'h7},
        {3'h5,3'h7,3'h7,3'h5,3'h5}, {3'h5,3'h7,3'h7,3'h7,3'h5}, {3'h7,3'h5,3'h5,3'h5,3'h7},
        {3'h7,3'h5,3'h7,3'h4,3'h4}, {3'h7,3'h5,3'h5,3'h7,3'h7}, {3'h7,3'h5,3'h7,3'h6,3'h5},
        {3'h7,3'h4,3'h7,3'h1,3'h7}, {3'h7,3'h2,3'h2,3'h2,3'h2}, {3'h5,3'h5,3'h5,3'h5,3'h7},
        {3'h5,3'h5,3'h5,3'h5,3'h2}, {3'h5,3'h5,3'h7,3'h7,3'h5}, {3'h5,3'h5,3'h2,3'h5,3'h5},
        {3'h5,3'h5,3'h7,3'h2,3'h2}, {3'h7,3'h1,3'h2,3'h4,3'h7},
        {3'h0,3'h0,3'h0,3'h0,3'h0}, {3'h7,3'h1,3'h7,3'h0,3'h0}
    };

    function automatic logic [5:0] glyph_of(input logic [7:0] ch);
        logic [5:0] g;
        g = GLYPH_NONE;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            g = 6'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h5a) begin
            g = 6'(ch - 8'h41) + 6'd10;
        end else if (ch >= 8'h61 && ch <= 8'h7a) begin
            g = 6'(ch - 8'h61) + 6'd10;
        end else if (ch == 8'h20) begin
            g = GLYPH_SPACE;
        end else if (ch == 8'h25) begin
            g = GLYPH_PERCENT;
        end
        return g;
    endfunction

    function automatic logic glyph_hit(input logic [5:0] g, input logic [1:0] dx,
                                       input logic [2:0] gy);
        logic [14:0] bits;
        logic [2:0]  line;
        bits = '0;
        line = '0;
        if (g < 6'(GLYPH_COUNT)) begin
            bits = FONT[g];
        end
        case (gy)
            3'd0:    line = bits[14:12];
            3'd1:    line = bits[11:9];
            3'd2:    line = bits[8:6];
            3'd3:    line = bits[5:3];
            3'd4:    line = bits[2:0];
            default: line = '0;
        endcase
        return (dx != 2'd3) && line[2'd2 - dx];
    endfunction

endpackage

@@ rtl/ptbo_cfg.sv @@
// ----------------------------------------------------------------------------
// ptbo_cfg
// Configuration register file for the overlay, written through a plain port.
// ----------------------------------------------------------------------------
module ptbo_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ptbo_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ptbo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output ptbo_pkg::ptbo_cfg_t                cfg
);
    import ptbo_pkg::*;

    ptbo_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (ptbo_reg_t'(cfg_addr))
                REG_ENABLE:     cfg_reg.overlay_enable   <= cfg_wdata[0];
                REG_BOX_LEFT:   cfg_reg.box_left         <= $signed(cfg_wdata[8:0]);
                REG_BOX_TOP:    cfg_reg.box_top          <= $signed(cfg_wdata[8:0]);
                REG_BOX_WIDTH:  cfg_reg.box_width        <= cfg_wdata[7:0];
                REG_BOX_HEIGHT: cfg_reg.box_height       <= cfg_wdata[7:0];
                REG_CONFIDENCE: cfg_reg.confidence_value <= cfg_wdata[7:0];
                REG_LABEL:      cfg_reg.label_text       <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pixel_text_box_overlay.sv @@
// ----------------------------------------------------------------------------
// pixel_text_box_overlay
// Draws a text band and a bounding box over a pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock when the output is not stalled and
// passes it through a three-stage pipeline: the first stage finds the text
// slot and box edges of the pixel, the second picks the glyph, and the third
// reads the font and forms the output. Sustained rate is one beat per cycle;
// a stalled output holds the pipeline and bubbles are filled while it waits.
module pixel_text_box_overlay (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,  // pixel_in, column, row
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,  // pixel_out
    input  logic                               cfg_we,
    input  logic [ptbo_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ptbo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ptbo_pkg::*;

    typedef struct packed {
        logic [7:0] pix;
        logic       active;
        logic       band;
        logic       gy_ok;
        logic [2:0] gy;
        logic       l_ok;
        logic [5:0] l_slot;
        logic [1:0] l_dx;
        logic       d_ok;
        logic [5:0] d_slot;
        logic [1:0] d_dx;
        logic       on_y;
        logic       in_x;
        logic       on_x;
        logic       in_y;
    } s1_t;

    typedef struct packed {
        logic [7:0] pix;
        logic       active;
        logic       band;
        logic       gy_ok;
        logic [2:0] gy;
        logic [5:0] l_glyph;
        logic [1:0] l_dx;
        logic [5:0] d_glyph;
        logic [1:0] d_dx;
        logic       rect;
    } s2_t;

    ptbo_cfg_t cfg;

    ptbo_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Values that follow from the configuration alone.
    logic [3:0]         label_len;
    logic [5:0]         digit_base;
    logic [1:0]         hund;
    logic [6:0]         rem100;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [3:0]         ones;
    logic [1:0]         num_digits;
    logic signed [10:0] x1, x2, y1, y2;
    logic               box_on;

    always_comb begin
        label_len = 4'(LABEL_CHARS);
        for (int i = LABEL_CHARS - 1; i >= 0; i--) begin
            if (cfg.label_text[8*i +: 8] == 8'h00) begin
                label_len = 4'(i);
            end
        end
    end

    assign digit_base = 6'd3 + {label_len, 2'b00};
    assign hund       = (cfg.confidence_value >= 8'd200) ? 2'd2 :
                        (cfg.confidence_value >= 8'd100) ? 2'd1 : 2'd0;
    assign rem100     = 7'(cfg.confidence_value - 8'(hund) * 8'd100);
    assign tens_prod  = 15'(rem100) * 15'd205;
    assign tens       = tens_prod[14:11];
    assign ones       = 4'(rem100 - 7'(tens) * 7'd10);
    assign num_digits = (cfg.confidence_value >= 8'd100) ? 2'd3 :
                        (cfg.confidence_value >= 8'd10) ? 2'd2 : 2'd1;
    assign x1         = 11'(cfg.box_left) - 11'sd1;
    assign y1         = 11'(cfg.box_top) - 11'sd1;
    assign x2         = 11'(cfg.box_left) + $signed({3'b000, cfg.box_width});
    assign y2         = 11'(cfg.box_top) + $signed({3'b000, cfg.box_height});
    assign box_on     = (cfg.box_width != 8'd0) && (cfg.box_height != 8'd0);

    // Handshake: a stage loads when it is empty or its successor loads.
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !m_valid_reg || m_tready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: slot positions and box edge tests.
    logic [7:0]         in_pix, in_col, in_row;
    logic [7:0]         xl;
    logic [8:0]         xd;
    logic signed [10:0] xs, ys;
    s1_t                s1_next, s1_reg;

    assign in_pix = s_tdata[7:0];
    assign in_col = s_tdata[15:8];
    assign in_row = s_tdata[23:16];
    assign xl     = in_col - 8'd1;
    assign xd     = {1'b0, in_col} - 9'(digit_base);
    assign xs     = $signed({3'b000, in_col});
    assign ys     = $signed({3'b000, in_row});

    always_comb begin
        s1_next.pix    = in_pix;
        s1_next.active = cfg.overlay_enable && (11'(in_col) < 11'(MAX_WIDTH))
                         && (11'(in_row) < 11'(MAX_HEIGHT));
        s1_next.band   = in_row < 8'(BAND_ROWS);
        s1_next.gy_ok  = (in_row >= 8'd1) && (in_row <= 8'd5);
        s1_next.gy     = 3'(in_row - 8'd1);
        s1_next.l_ok   = in_col >= 8'd1;
        s1_next.l_slot = xl[7:2];
        s1_next.l_dx   = xl[1:0];
        s1_next.d_ok   = in_col >= 8'(digit_base);
        s1_next.d_slot = xd[7:2];
        s1_next.d_dx   = xd[1:0];
        s1_next.on_y   = (ys == y1) || (ys == y2);
        s1_next.in_x   = (xs >= x1) && (xs <= x2);
        s1_next.on_x   = (xs == x1) || (xs == x2);
        s1_next.in_y   = (ys >= y1) && (ys <= y2);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: glyph selection and rectangle decision.
    s2_t        s2_next, s2_reg;
    logic [7:0] label_byte;
    logic [3:0] digit_val;

    assign label_byte = cfg.label_text[8*s1_reg.l_slot[2:0] +: 8];

    always_comb begin
        digit_val = ones;
        case (num_digits)
            2'd3: begin
                digit_val = (s1_reg.d_slot[1:0] == 2'd0) ? 4'(hund) :
                            (s1_reg.d_slot[1:0] == 2'd1) ? tens : ones;
            end
            2'd2: begin
                digit_val = (s1_reg.d_slot[1:0] == 2'd0) ? tens : ones;
            end
            default: digit_val = ones;
        endcase

        s2_next.pix     = s1_reg.pix;
        s2_next.active  = s1_reg.active;
        s2_next.band    = s1_reg.band;
        s2_next.gy_ok   = s1_reg.gy_ok;
        s2_next.gy      = s1_reg.gy;
        s2_next.l_dx    = s1_reg.l_dx;
        s2_next.d_dx    = s1_reg.d_dx;
        s2_next.l_glyph = GLYPH_NONE;
        if (s1_reg.l_ok && (s1_reg.l_slot < 6'(label_len))) begin
            s2_next.l_glyph = glyph_of(label_byte);
        end
        s2_next.d_glyph = GLYPH_NONE;
        if (s1_reg.d_ok) begin
            if (s1_reg.d_slot < 6'(num_digits)) begin
                s2_next.d_glyph = 6'(digit_val);
            end else if (s1_reg.d_slot == 6'(num_digits)) begin
                s2_next.d_glyph = GLYPH_PERCENT;
            end
        end
        s2_next.rect = box_on && ((s1_reg.on_y && s1_reg.in_x)
                                  || (s1_reg.on_x && s1_reg.in_y));
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: font lookup and output pixel.
    logic       text_hit;
    logic [7:0] pix_next, m_data_reg;

    assign text_hit = s2_reg.gy_ok
                      && (glyph_hit(s2_reg.l_glyph, s2_reg.l_dx, s2_reg.gy)
                          || glyph_hit(s2_reg.d_glyph, s2_reg.d_dx, s2_reg.gy));

    always_comb begin
        pix_next = s2_reg.pix;
        if (s2_reg.active) begin
            if (s2_reg.band) begin
                pix_next = text_hit ? 8'hff : 8'h00;
            end else if (s2_reg.rect) begin
                pix_next = 8'hff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            m_data_reg <= pix_next;
        end
    end

    assign m_tdata = m_data_reg;

endmodule

@@ test/pixel_text_box_overlay_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_text_box_overlay_tb
// Self-checking testbench for the text band and bounding box overlay. Pixels
// are streamed in under several register settings and idle patterns. Every
// output beat is compared with a pixel computed from the testbench's own
// model of the font, label, confidence, percent sign and box outline.
// ----------------------------------------------------------------------------
import ptbo_pkg::*;

typedef struct {
    bit [23:0] beat;
    bit [7:0]  pixel;
} overlay_expect_t;

class overlay_scoreboard;
    ptbo_cfg_t       cfg;
    overlay_expect_t pending_pixels[$];
    int              errors;

    function new();
        cfg    = '0;
        errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, bit [63:0] value);
        case (idx)
            REG_ENABLE:     cfg.overlay_enable   = value[0];
            REG_BOX_LEFT:   cfg.box_left         = value[8:0];
            REG_BOX_TOP:    cfg.box_top          = value[8:0];
            REG_BOX_WIDTH:  cfg.box_width        = value[7:0];
            REG_BOX_HEIGHT: cfg.box_height       = value[7:0];
            REG_CONFIDENCE: cfg.confidence_value = value[7:0];
            REG_LABEL:      cfg.label_text       = value;
            default: ;
        endcase
    endfunction

    function bit [14:0] font_bits(int g);
        case (g)
            0:  return {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
            1:  return {3'h2, 3'h6, 3'h2, 3'h2, 3'h7};
            2:  return {3'h7, 3'h1, 3'h7, 3'h4, 3'h7};
            3:  return {3'h7, 3'h1, 3'h7, 3'h1, 3'h7};
            4:  return {3'h5, 3'h5, 3'h7, 3'h1, 3'h1};
            5:  return {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
            6:  return {3'h7, 3'h4, 3'h7, 3'h5, 3'h7};
            7:  return {3'h7, 3'h1, 3'h1, 3'h1, 3'h1};
            8:  return {3'h7, 3'h5, 3'h7, 3'h5, 3'h7};
            9:  return {3'h7, 3'h5, 3'h7, 3'h1, 3'h7};
            10: return {3'h2, 3'h5, 3'h7, 3'h5, 3'h5};
            11: return {3'h6, 3'h5, 3'h6, 3'h5, 3'h6};
            12: return {3'h7, 3'h4, 3'h4, 3'h4, 3'h7};
            13: return {3'h6, 3'h5, 3'h5, 3'h5, 3'h6};
            14: return {3'h7, 3'h4, 3'h7, 3'h4, 3'h7};
            15: return {3'h7, 3'h4, 3'h7, 3'h4, 3'h4};
            16: return {3'h7, 3'h4, 3'h5, 3'h5, 3'h7};
            17: return {3'h5, 3'h5, 3'h7, 3'h5, 3'h5};
            18: return {3'h7, 3'h2, 3'h2, 3'h2, 3'h7};
            19: return {3'h1, 3'h1, 3'h1, 3'h5, 3'h7};
            20: return {3'h5, 3'h5, 3'h6, 3'h5, 3'h5};
            21: return {3'h4, 3'h4, 3'h4, 3'h4, 3'h7};
            22: return {3'h5, 3'h7, 3'h7, 3'h5, 3'h5};
            23: return {3'h5, 3'h7, 3'h7, 3'h7, 3'h5};
            24: return {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
            25: return {3'h7, 3'h5, 3'h7, 3'h4, 3'h4};
            26: return {3'h7, 3'h5, 3'h5, 3'h7, 3'h7};
            27: return {3'h7, 3'h5, 3'h7, 3'h6, 3'h5};
            28: return {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
            29: return {3'h7, 3'h2, 3'h2, 3'h2, 3'h2};
            30: return {3'h5, 3'h5, 3'h5, 3'h5, 3'h7};
            31: return {3'h5, 3'h5, 3'h5, 3'h5, 3'h2};
            32: return {3'h5, 3'h5, 3'h7, 3'h7, 3'h5};
            33: return {3'h5, 3'h5, 3'h2, 3'h5, 3'h5};
            34: return {3'h5, 3'h5, 3'h7, 3'h2, 3'h2};
            35: return {3'h7, 3'h1, 3'h2, 3'h4, 3'h7};
            37: return {3'h7, 3'h1, 3'h7, 3'h0, 3'h0};
            default: return '0;
        endcase
    endfunction

    function bit glyph_lit(int g, int dx, int gy);
        bit [14:0] bits;
        if (g >= GLYPH_COUNT || dx < 0 || dx > 2 || gy < 0 || gy > 4) begin
            return 1'b0;
        end
        bits = font_bits(g);
        return bits[14 - 3 * gy - dx];
    endfunction

    function int char_glyph(bit [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return ch - "0";
        end
        if (ch >= "A" && ch <= "Z") begin
            return ch - "A" + 10;
        end
        if (ch >= "a" && ch <= "z") begin
            return ch - "a" + 10;
        end
        if (ch == " ") begin
            return GLYPH_SPACE;
        end
        if (ch == "%") begin
            return GLYPH_PERCENT;
        end
        return GLYPH_NONE;
    endfunction

    function bit text_lit(int x, int y);
        int        gy;
        int        len;
        int        nd;
        int        v;
        int        base;
        int        digs[3];
        bit [7:0]  ch;
        gy = y - 1;
        if (gy < 0 || gy > 4) begin
            return 1'b0;
        end
        len = 0;
        while (len < LABEL_CHARS && cfg.label_text[8 * len +: 8] != 8'd0) begin
            ch = cfg.label_text[8 * len +: 8];
            if (glyph_lit(char_glyph(ch), x - (1 + 4 * len), gy)) begin
                return 1'b1;
            end
            len++;
        end
        v       = cfg.confidence_value;
        nd      = (v >= 100) ? 3 : ((v >= 10) ? 2 : 1);
        digs[0] = v / 100;
        digs[1] = (v / 10) % 10;
        digs[2] = v % 10;
        base    = 3 + 4 * len;
        for (int k = 0; k < nd; k++) begin
            if (glyph_lit(digs[3 - nd + k], x - (base + 4 * k), gy)) begin
                return 1'b1;
            end
        end
        return glyph_lit(GLYPH_PERCENT, x - (base + 4 * nd), gy);
    endfunction

    function void frame_bounds(output int x1, output int y1, output int x2, output int y2);
        x1 = $signed(cfg.box_left) - 1;
        y1 = $signed(cfg.box_top) - 1;
        x2 = $signed(cfg.box_left) + int'(cfg.box_width);
        y2 = $signed(cfg.box_top) + int'(cfg.box_height);
    endfunction

    function bit frame_lit(int x, int y);
        int x1;
        int y1;
        int x2;
        int y2;
        if (cfg.box_width == 8'd0 || cfg.box_height == 8'd0) begin
            return 1'b0;
        end
        frame_bounds(x1, y1, x2, y2);
        if ((y == y1 || y == y2) && x >= x1 && x <= x2) begin
            return 1'b1;
        end
        return (x == x1 || x == x2) && y >= y1 && y <= y2;
    endfunction

    function bit [7:0] overlay_pixel(bit [23:0] beat);
        int       x;
        int       y;
        bit [7:0] res;
        res = beat[7:0];
        x   = beat[15:8];
        y   = beat[23:16];
        if (cfg.overlay_enable && x < MAX_WIDTH && y < MAX_HEIGHT) begin
            if (y < BAND_ROWS) begin
                res = text_lit(x, y) ? 8'd255 : 8'd0;
            end else if (frame_lit(x, y)) begin
                res = 8'd255;
            end
        end
        return res;
    endfunction

    function void note_pixel(bit [23:0] beat);
        overlay_expect_t e;
        e.beat  = beat;
        e.pixel = overlay_pixel(beat);
        pending_pixels.push_back(e);
    endfunction

    function void check_pixel(bit [7:0] got, time stamp);
        overlay_expect_t e;
        if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected output beat, expected none, actual %0d", stamp, got);
            return;
        end
        e = pending_pixels.pop_front();
        if (got != e.pixel) begin
            errors++;
            $display("%0t ns: pixel_out mismatch (pixel %0d column %0d row %0d), expected %0d, actual %0d",
                     stamp, e.beat[7:0], e.beat[15:8], e.beat[23:16], e.pixel, got);
        end
    endfunction
endclass

module pixel_text_box_overlay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;
    localparam int PIPE_DEPTH     = 3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENTS       = 12;
    localparam int SEGMENT_BEATS  = 70;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [23:0]             s_tdata   = '0;  // pixel_in, column, row
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [7:0]              m_tdata;         // pixel_out
    logic                    cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    overlay_scoreboard sb = new();
    int src_idle     = 0;
    int sink_stall   = 0;
    int quiet_cycles = 0;

    pixel_text_box_overlay u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_pixel(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_pixel(m_tdata, $time);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pixel_text_box_overlay_tb failed");
            $finish;
        end
    end

    function automatic bit [23:0] beat_of(bit [7:0] pix, bit [7:0] col, bit [7:0] row);
        return {row, col, pix};
    endfunction

    task automatic push_pixel(input bit [23:0] beat);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx, input bit [63:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(input ptbo_cfg_t c);
        bit [63:0] junk;
        junk = {$urandom, $urandom};
        program_reg(REG_ENABLE, {junk[63:1], c.overlay_enable});
        program_reg(REG_BOX_LEFT, {junk[63:9], c.box_left});
        program_reg(REG_BOX_TOP, {junk[63:9], c.box_top});
        program_reg(REG_BOX_WIDTH, {junk[63:8], c.box_width});
        program_reg(REG_BOX_HEIGHT, {junk[63:8], c.box_height});
        program_reg(REG_CONFIDENCE, {junk[63:8], c.confidence_value});
        program_reg(REG_LABEL, c.label_text);
        program_reg(REG_SPARE, junk);
        cfg_we <= 1'b0;
    endtask

    function automatic ptbo_cfg_t pick_settings(int seg);
        ptbo_cfg_t c;
        int        len;
        string     glyph_chars;
        glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz %";
        c.overlay_enable = ($urandom_range(6) != 0);
        c.box_left   = $urandom_range(1) ? 9'($urandom) : 9'($urandom_range(208) - 8);
        c.box_top    = $urandom_range(1) ? 9'($urandom) : 9'($urandom_range(208) - 8);
        c.box_width  = ($urandom_range(9) == 0) ? 8'd0 :
                       ($urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 40)));
        c.box_height = ($urandom_range(9) == 0) ? 8'd0 :
                       ($urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 40)));
        case ($urandom_range(3))
            0: c.confidence_value = 8'($urandom_range(9));
            1: c.confidence_value = 8'($urandom_range(10, 99));
            2: c.confidence_value = 8'($urandom_range(100, 255));
            default: c.confidence_value = $urandom_range(1) ? 8'd99 : 8'd100;
        endcase
        c.label_text = '0;
        len = $urandom_range(LABEL_CHARS);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) begin
                c.label_text[8 * i +: 8] = 8'($urandom_range(1, 255));
            end else begin
                c.label_text[8 * i +: 8] = glyph_chars[$urandom_range(glyph_chars.len() - 1)];
            end
        end
        case (seg)
            0: begin
                c.overlay_enable   = 1'b1;
                c.box_left         = 9'h100;
                c.box_top          = 9'h100;
                c.box_width        = 8'd0;
                c.box_height       = 8'd0;
                c.confidence_value = 8'd0;
                c.label_text       = '0;
            end
            1: begin
                c.overlay_enable   = 1'b1;
                c.box_left         = 9'd255;
                c.box_top          = 9'd255;
                c.box_width        = 8'd255;
                c.box_height       = 8'd255;
                c.confidence_value = 8'd255;
                c.label_text       = '1;
            end
            2: begin
                c.overlay_enable = 1'b1;
                c.box_left       = 9'd4;
                c.box_top        = 9'd2;
                c.box_width      = 8'd30;
                c.box_height     = 8'd10;
            end
            3: c.overlay_enable = 1'b0;
            default: ;
        endcase
        return c;
    endfunction

    function automatic bit [23:0] make_beat();
        int x1;
        int y1;
        int x2;
        int y2;
        int col;
        int row;
        sb.frame_bounds(x1, y1, x2, y2);
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                row = $urandom_range(BAND_ROWS);
                col = $urandom_range(55);
            end
            4, 5, 6: begin
                if ($urandom_range(1)) begin
                    row = ($urandom_range(1) ? y1 : y2) + int'($urandom_range(2)) - 1;
                    col = x1 - 1 + int'($urandom_range(x2 - x1 + 2));
                end else begin
                    col = ($urandom_range(1) ? x1 : x2) + int'($urandom_range(2)) - 1;
                    row = y1 - 1 + int'($urandom_range(y2 - y1 + 2));
                end
            end
            default: begin
                row = $urandom_range(255);
                col = $urandom_range(255);
            end
        endcase
        return beat_of(8'($urandom), 8'(col), 8'(row));
    endfunction

    initial begin
        ptbo_cfg_t demo;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_pixel(beat_of(8'd255, 8'd255, 8'd255));
        push_pixel(beat_of(8'd0, 8'd0, 8'd0));
        push_pixel(beat_of(8'hA5, 8'd3, 8'd2));
        drain();

        demo                  = '0;
        demo.overlay_enable   = 1'b1;
        demo.box_left         = 9'd10;
        demo.box_top          = 9'd20;
        demo.box_width        = 8'd5;
        demo.box_height       = 8'd4;
        demo.confidence_value = 8'd7;
        demo.label_text       = 64'h0000_2125_2039_5A61;
        apply_settings(demo);
        push_pixel(beat_of(8'hA5, 8'd1, 8'd0));
        push_pixel(beat_of(8'h5A, 8'd2, 8'd1));
        push_pixel(beat_of(8'h00, 8'd5, 8'd3));
        push_pixel(beat_of(8'hFF, 8'd9, 8'd6));
        push_pixel(beat_of(8'h11, 8'd13, 8'd5));
        push_pixel(beat_of(8'h22, 8'd17, 8'd2));
        push_pixel(beat_of(8'h33, 8'd21, 8'd2));
        push_pixel(beat_of(8'h44, 8'd27, 8'd1));
        push_pixel(beat_of(8'h55, 8'd31, 8'd1));
        push_pixel(beat_of(8'h66, 8'd33, 8'd2));
        push_pixel(beat_of(8'h77, 8'd255, 8'd6));
        push_pixel(beat_of(8'h88, 8'd0, 8'd7));
        push_pixel(beat_of(8'h99, 8'd9, 8'd19));
        push_pixel(beat_of(8'hAA, 8'd15, 8'd24));
        push_pixel(beat_of(8'hBB, 8'd9, 8'd21));
        push_pixel(beat_of(8'hCC, 8'd15, 8'd21));
        push_pixel(beat_of(8'hDD, 8'd12, 8'd19));
        push_pixel(beat_of(8'hEE, 8'd12, 8'd21));
        push_pixel(beat_of(8'h01, 8'd16, 8'd24));
        push_pixel(beat_of(8'h80, 8'd255, 8'd255));
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 86; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 86; end
                default: begin src_idle = 28; sink_stall = 28; end
            endcase
            apply_settings(pick_settings(seg));
            repeat (SEGMENT_BEATS) push_pixel(make_beat());
            drain();
        end

        if (sb.errors == 0) begin
            $display("pixel_text_box_overlay_tb passed");
        end else begin
            $display("pixel_text_box_overlay_tb failed");
        end
        $finish;
    end
endmodule
